// ----- design/pvc_pkg.sv -----
// Shared types, widths and register codes for the position-to-velocity command block.
// Used by every module of the block; depends on nothing.
package pvc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_BITS   = 18;
  localparam int FIFO_DEPTH = 4;

  localparam int DIFF_W = POS_BITS + 1;
  localparam int SQ_W   = 2 * POS_BITS;
  localparam int RAD_W  = 2 * POS_BITS + 2;
  localparam int ROOT_W = POS_BITS + 1;

  localparam int GAIN_W = 16;
  localparam int FAR_W  = 19;
  localparam int SPD_W  = 16;
  localparam int VEL_W  = 17;
  localparam int LIN_W  = GAIN_W + ROOT_W;
  localparam int DD_W   = 2 * ROOT_W;
  localparam int LQ_W   = GAIN_W + 2 * ROOT_W;
  localparam int SHR_W  = LQ_W - 2 * FRAC_BITS;
  localparam int DIV_W  = SPD_W + ROOT_W;

  localparam int IN_DATA_W  = ((6 * POS_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * VEL_W + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd11469;
  localparam logic [GAIN_W-1:0] QUAD_RST  = 16'd6554;
  localparam logic [SPD_W-1:0]  MAX_RST   = 16'd3604;
  localparam logic [FAR_W-1:0]  FAR_RST   = 19'd19661;
  localparam logic [SPD_W-1:0]  SPD_LIMIT = 16'd65535;

  typedef enum logic [1:0] {
    REG_GAIN,
    REG_QUAD,
    REG_MAX,
    REG_FAR
  } pvc_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0] quad_coeff;
    logic [SPD_W-1:0]  max_speed;
    logic [FAR_W-1:0]  far_distance;
  } pvc_cfg_t;

  // Distance and difference vector handed from the front to the back.
  typedef struct packed {
    logic [ROOT_W-1:0]           dlen;
    logic [2:0][DIFF_W-1:0]      diff;
  } pvc_item_t;

endpackage

// ----- design/pvc_front.sv -----
// Front end: difference vector, sum of squares and a pipelined integer square root.
// Depends on pvc_pkg.
module pvc_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [2:0][pvc_pkg::POS_BITS-1:0]       tgt,
  input  logic [2:0][pvc_pkg::POS_BITS-1:0]       cur,
  output logic                                    out_valid,
  output pvc_pkg::pvc_item_t                      out_item
);

  localparam int P  = pvc_pkg::POS_BITS;
  localparam int DW = pvc_pkg::DIFF_W;
  localparam int RW = pvc_pkg::RAD_W;
  localparam int QW = pvc_pkg::ROOT_W;
  localparam int NV = QW + 3;

  logic [NV-1:0]                 v_r;
  logic [2:0][DW-1:0]            diff0_r;
  logic [2:0][DW-1:0]            diff1_r;
  logic [2:0][pvc_pkg::SQ_W-1:0] sq_r;
  logic [RW-1:0]                 rem_r  [0:QW];
  logic [QW-1:0]                 root_r [0:QW];
  logic [2:0][DW-1:0]            dif_r  [0:QW];
  logic [2:0][DW-1:0]            diff_nxt;
  logic [2:0][P-1:0]             mag;
  logic [RW-1:0]                 rad_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_nxt[i] = {tgt[i][P-1], tgt[i]} - {cur[i][P-1], cur[i]};
      mag[i] = diff0_r[i][DW-1] ? P'(-diff0_r[i]) : P'(diff0_r[i]);
    end
    rad_nxt = RW'(sq_r[0]) + RW'(sq_r[1]) + RW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NV-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff0_r <= diff_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mag[i] * mag[i];
      end
      diff1_r   <= diff0_r;
      rem_r[0]  <= rad_nxt;
      root_r[0] <= '0;
      dif_r[0]  <= diff1_r;
    end
  end

  // One root bit per stage, most significant first; the remainder holds radicand minus root squared.
  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    localparam int B = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          take;

    always_comb begin
      trial = (RW'(root_r[k]) << (B + 1)) | (RW'(1) << (2 * B));
      take  = rem_r[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
        root_r[k+1] <= take ? (root_r[k] | (QW'(1) << B)) : root_r[k];
        dif_r[k+1]  <= dif_r[k];
      end
    end
  end

  assign out_valid     = v_r[NV-1];
  assign out_item.dlen = root_r[QW];
  assign out_item.diff = dif_r[QW];

endmodule

// ----- design/pvc_fifo.sv -----
// Short queue of front-end results between the front and the back end.
// Depends on pvc_pkg for the item type.
module pvc_fifo #(
  parameter int DEPTH = pvc_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pvc_pkg::pvc_item_t push_item,
  input  logic               pop,
  output logic               not_empty,
  output logic               full,
  output pvc_pkg::pvc_item_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pvc_pkg::pvc_item_t mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == CW'(DEPTH);
  assign head      = mem_r[rd_ptr_r];

endmodule

// ----- design/pvc_back.sv -----
// Back end: speed law, per-axis scaling by speed over distance and the output register.
// Depends on pvc_pkg.
module pvc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pvc_pkg::pvc_cfg_t                   cfg,
  input  logic                                in_valid,
  input  pvc_pkg::pvc_item_t                  in_item,
  output logic                                in_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pvc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [0:0]                          out_tuser
);

  localparam int DW  = pvc_pkg::DIFF_W;
  localparam int QW  = pvc_pkg::ROOT_W;
  localparam int SW  = pvc_pkg::SPD_W;
  localparam int VW  = pvc_pkg::VEL_W;
  localparam int LQ  = pvc_pkg::LQ_W;
  localparam int FB  = pvc_pkg::FRAC_BITS;
  localparam int XW  = pvc_pkg::DIV_W;
  localparam int NV  = 4 + SW;

  logic                           en;
  logic [NV-1:0]                  v_r;

  logic [QW-1:0]                  d0_r, d1_r, d2_r;
  logic [2:0][DW-1:0]             dif0_r, dif1_r, dif2_r;
  logic [pvc_pkg::LIN_W-1:0]      lin0_r;
  logic [pvc_pkg::DD_W-1:0]       dd0_r;
  logic                           far0_r, far1_r, zero0_r, zero1_r, zero2_r;
  logic [LQ-1:0]                  lin1_r, quad1_r;
  logic [SW-1:0]                  spd_r;
  logic                           spd_neg_r;
  logic [SW-1:0]                  spd_nxt;
  logic                           spd_neg_nxt;
  logic [LQ-1:0]                  net;
  logic [pvc_pkg::SHR_W-1:0]      shr;

  logic [2:0][XW-1:0]             pr_r  [0:SW];
  logic [2:0][SW-1:0]             qt_r  [0:SW];
  logic [QW-1:0]                  dv_r  [0:SW];
  logic [2:0]                     ng_r  [0:SW];
  logic                           zr_r  [0:SW];

  logic                           out_valid_r;
  logic [3*VW-1:0]                vel_r;
  logic                           at_r;
  logic [3*VW-1:0]                vel_nxt;

  assign en     = !out_valid_r || out_tready;
  assign in_pop = en && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NV-2:0], in_valid};
      out_valid_r <= v_r[NV-1];
    end
  end

  // Speed law: ceiling when far; else positive clamps to it, negative to full-scale limit.
  always_comb begin
    net         = (lin1_r >= quad1_r) ? lin1_r - quad1_r : quad1_r - lin1_r;
    shr         = net[LQ-1:2*FB];
    spd_nxt     = cfg.max_speed;
    spd_neg_nxt = 1'b0;
    priority if (far1_r) begin
      spd_nxt = cfg.max_speed;
    end else if (lin1_r >= quad1_r) begin
      spd_nxt = (shr > pvc_pkg::SHR_W'(cfg.max_speed)) ? cfg.max_speed : SW'(shr);
    end else begin
      spd_nxt     = (shr > pvc_pkg::SHR_W'(pvc_pkg::SPD_LIMIT)) ? pvc_pkg::SPD_LIMIT
                                                               : SW'(shr);
      spd_neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r    <= in_item.dlen;
      dif0_r  <= in_item.diff;
      lin0_r  <= in_item.dlen * cfg.gain;
      dd0_r   <= in_item.dlen * in_item.dlen;
      far0_r  <= in_item.dlen > cfg.far_distance;
      zero0_r <= in_item.dlen == '0;

      d1_r    <= d0_r;
      dif1_r  <= dif0_r;
      lin1_r  <= LQ'({lin0_r, {FB{1'b0}}});
      quad1_r <= dd0_r * cfg.quad_coeff;
      far1_r  <= far0_r;
      zero1_r <= zero0_r;

      d2_r      <= d1_r;
      dif2_r    <= dif1_r;
      spd_r     <= spd_nxt;
      spd_neg_r <= spd_neg_nxt;
      zero2_r   <= zero1_r;

      for (int i = 0; i < 3; i++) begin
        pr_r[0][i] <= XW'(spd_r) * XW'(dif2_r[i][DW-1] ? pvc_pkg::POS_BITS'(-dif2_r[i])
                                                       : pvc_pkg::POS_BITS'(dif2_r[i]));
        ng_r[0][i] <= spd_neg_r ^ dif2_r[i][DW-1];
      end
      qt_r[0] <= '0;
      dv_r[0] <= d2_r;
      zr_r[0] <= zero2_r;
    end
  end

  // Restoring division, one quotient bit per stage; the quotient never exceeds the speed.
  for (genvar j = 0; j < SW; j++) begin : g_div
    localparam int Q = SW - 1 - j;
    logic [XW-1:0] dsh;

    assign dsh = XW'(dv_r[j]) << Q;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (pr_r[j][i] >= dsh) begin
            pr_r[j+1][i] <= pr_r[j][i] - dsh;
            qt_r[j+1][i] <= qt_r[j][i] | (SW'(1) << Q);
          end else begin
            pr_r[j+1][i] <= pr_r[j][i];
            qt_r[j+1][i] <= qt_r[j][i];
          end
        end
        dv_r[j+1] <= dv_r[j];
        ng_r[j+1] <= ng_r[j];
        zr_r[j+1] <= zr_r[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zr_r[SW]) begin
        vel_nxt[i*VW +: VW] = '0;
      end else if (ng_r[SW][i]) begin
        vel_nxt[i*VW +: VW] = -VW'(qt_r[SW][i]);
      end else begin
        vel_nxt[i*VW +: VW] = VW'(qt_r[SW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_r <= vel_nxt;
      at_r  <= zr_r[SW];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pvc_pkg::OUT_DATA_W'(vel_r);
  assign out_tuser  = at_r;

endmodule

// ----- design/position_to_velocity_command.sv -----
// Saturated proportional velocity command: target and current position in, velocity out.
// Usage: a beat on the in_ channel carries six Q2.16 positions; one beat on the out_
// channel carries the three-axis velocity and an at-target flag.
// The front end forms the difference vector and its length with a 19-stage square root;
// a four-entry queue feeds the back end, which applies the speed law and divides each
// axis by the distance through 16 restoring stages, then holds the result in an output
// register.
// Throughput is one beat per cycle when nothing stalls: every stage is a register
// stage with no iteration. When the receiver stalls, the back end freezes while the
// front end runs on until the queue is full and a beat waits in its last stage;
// in_tready then drops.
// Reset (rst_n low, synchronous) empties the pipeline and queue and loads the default
// gain, quad_coeff, max_speed and far_distance; the block accepts beats immediately after.
// The user must write registers via the APB port only while idle; the block has no check.
// pready is always high. Depends on pvc_pkg, pvc_front, pvc_fifo and pvc_back.
module position_to_velocity_command #(
  parameter int FIFO_DEPTH = pvc_pkg::FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // target_x, target_y, target_z, current_x, current_y, current_z, zero fill
  input  logic [pvc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vel_x, vel_y, vel_z, zero fill
  output logic [pvc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // at_target
  output logic [0:0]                        out_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int P = pvc_pkg::POS_BITS;

  pvc_pkg::pvc_cfg_t                cfg_r;
  pvc_pkg::pvc_reg_t                reg_sel;
  logic                             wr_en;
  logic [2:0][P-1:0]                tgt, cur;
  logic                             front_en, front_valid;
  pvc_pkg::pvc_item_t               front_item, head;
  logic                             fifo_push, fifo_pop, fifo_not_empty, fifo_full;

  assign pready  = 1'b1;
  assign reg_sel = pvc_pkg::pvc_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain         <= pvc_pkg::GAIN_RST;
      cfg_r.quad_coeff   <= pvc_pkg::QUAD_RST;
      cfg_r.max_speed    <= pvc_pkg::MAX_RST;
      cfg_r.far_distance <= pvc_pkg::FAR_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        pvc_pkg::REG_GAIN: cfg_r.gain         <= pwdata[pvc_pkg::GAIN_W-1:0];
        pvc_pkg::REG_QUAD: cfg_r.quad_coeff   <= pwdata[pvc_pkg::GAIN_W-1:0];
        pvc_pkg::REG_MAX:  cfg_r.max_speed    <= pwdata[pvc_pkg::SPD_W-1:0];
        pvc_pkg::REG_FAR:  cfg_r.far_distance <= pwdata[pvc_pkg::FAR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pvc_pkg::REG_GAIN: prdata = 32'(cfg_r.gain);
      pvc_pkg::REG_QUAD: prdata = 32'(cfg_r.quad_coeff);
      pvc_pkg::REG_MAX:  prdata = 32'(cfg_r.max_speed);
      pvc_pkg::REG_FAR:  prdata = 32'(cfg_r.far_distance);
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tgt[i] = in_tdata[i*P +: P];
      cur[i] = in_tdata[(i+3)*P +: P];
    end
  end

  // The front end only halts when its last stage holds a beat and the queue has no room.
  assign front_en  = !(front_valid && fifo_full);
  assign in_tready = front_en;
  assign fifo_push = front_en && front_valid;

  pvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_en),
    .in_valid  (in_tvalid),
    .tgt       (tgt),
    .cur       (cur),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  pvc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_item (front_item),
    .pop       (fifo_pop),
    .not_empty (fifo_not_empty),
    .full      (fifo_full),
    .head      (head)
  );

  pvc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (fifo_not_empty),
    .in_item    (head),
    .in_pop     (fifo_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("queue written while full");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (fifo_full && front_valid))
    else $error("input stalled without a full queue");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("non-zero velocity at target");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> fifo_not_empty)
    else $error("queue read while empty");
`endif

endmodule

// ----- tb/pvc_checker.sv -----
// Checker for the position-to-velocity command block: predicts each result beat from
// the accepted input beats and the current register settings. Depends on pvc_pkg.
`timescale 1ns / 100ps
module pvc_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [pvc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [pvc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic [0:0]                        out_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output int                                errors,
  output int                                pending
);

  localparam int P  = pvc_pkg::POS_BITS;
  localparam int VW = pvc_pkg::VEL_W;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vz;
    logic                 at;
  } vel_cmd_t;

  pvc_pkg::pvc_cfg_t cfg;
  vel_cmd_t vel_q[$];

  assign pending = vel_q.size();

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic vel_cmd_t command_for(logic [pvc_pkg::IN_DATA_W-1:0] d);
    longint diff [3];
    longint unsigned sumsq, dlen, lin, quad, s, m;
    longint spd, v;
    vel_cmd_t r;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = longint'($signed(d[i*P +: P])) - longint'($signed(d[(i+3)*P +: P]));
      sumsq += diff[i] * diff[i];
    end
    dlen = isqrt(sumsq);
    r = '0;
    if (dlen == 0) begin
      r.at = 1'b1;
      return r;
    end
    if (dlen > cfg.far_distance) spd = cfg.max_speed;
    else begin
      lin = (cfg.gain * dlen) << pvc_pkg::FRAC_BITS;
      quad = cfg.quad_coeff * dlen * dlen;
      if (lin >= quad) begin
        s = (lin - quad) >> (2 * pvc_pkg::FRAC_BITS);
        spd = (s > cfg.max_speed) ? cfg.max_speed : s;
      end else begin
        s = (quad - lin) >> (2 * pvc_pkg::FRAC_BITS);
        spd = (s > 65535) ? -65535 : -longint'(s);
      end
    end
    for (int i = 0; i < 3; i++) begin
      m = ((spd < 0 ? -spd : spd) * (diff[i] < 0 ? -diff[i] : diff[i])) / dlen;
      v = ((spd < 0) != (diff[i] < 0)) ? -longint'(m) : longint'(m);
      if (i == 0) r.vx = v[VW-1:0];
      else if (i == 1) r.vy = v[VW-1:0];
      else r.vz = v[VW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    vel_cmd_t got, exp_cmd;
    if (!rst_n) begin
      cfg <= '{gain: pvc_pkg::GAIN_RST, quad_coeff: pvc_pkg::QUAD_RST,
               max_speed: pvc_pkg::MAX_RST, far_distance: pvc_pkg::FAR_RST};
      vel_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          pvc_pkg::REG_GAIN: cfg.gain         <= pwdata[pvc_pkg::GAIN_W-1:0];
          pvc_pkg::REG_QUAD: cfg.quad_coeff   <= pwdata[pvc_pkg::GAIN_W-1:0];
          pvc_pkg::REG_MAX:  cfg.max_speed    <= pwdata[pvc_pkg::SPD_W-1:0];
          pvc_pkg::REG_FAR:  cfg.far_distance <= pwdata[pvc_pkg::FAR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) vel_q.push_back(command_for(in_tdata));
      if (out_tvalid && out_tready) begin
        got = '{vx: out_tdata[0 +: VW], vy: out_tdata[VW +: VW],
                vz: out_tdata[2*VW +: VW], at: out_tuser[0]};
        if (vel_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_cmd = vel_q.pop_front();
          if (got !== exp_cmd) begin
            $display("%0t: mismatch expected vx=%0d vy=%0d vz=%0d at=%0b",
                     $time, exp_cmd.vx, exp_cmd.vy, exp_cmd.vz, exp_cmd.at);
            $display("%0t:          actual   vx=%0d vy=%0d vz=%0d at=%0b",
                     $time, got.vx, got.vy, got.vz, got.at);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Top of the testbench: drives input beats, register writes and receiver stalls, and gives
// the verdict. Depends on pvc_pkg, pvc_checker and position_to_velocity_command.
`timescale 1ns / 100ps
module tb_top;

  localparam int P = pvc_pkg::POS_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [pvc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [pvc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int errors, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  position_to_velocity_command i_dut (.*);
  pvc_checker i_checker (.*);

  // Receiver: random stall, or a long hold-off when asked.
  always @(negedge clk)
    out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  task automatic write_reg(pvc_pkg::pvc_reg_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Called at a falling edge; in_tready only changes at rising edges, so it is stable here.
  task automatic send_beat(logic [pvc_pkg::IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [pvc_pkg::IN_DATA_W-1:0] pack_pos(logic [P-1:0] tx, ty, tz,
                                                             cx, cy, cz);
    return pvc_pkg::IN_DATA_W'({cz, cy, cx, tz, ty, tx});
  endfunction

  // Random positions; short differences often so the speed law is exercised.
  function automatic logic [pvc_pkg::IN_DATA_W-1:0] random_pos();
    logic [P-1:0] p [6];
    int span;
    span = ($urandom_range(3) == 0) ? (1 << 17) : (1 << $urandom_range(16, 2));
    for (int i = 0; i < 3; i++) begin
      p[i+3] = P'($urandom);
      p[i] = ($urandom_range(9) == 0) ? P'($urandom)
           : p[i+3] + P'($urandom_range(2 * span - 1) - span);
    end
    if ($urandom_range(30) == 0) p[0:2] = p[3:5];
    return pack_pos(p[0], p[1], p[2], p[3], p[4], p[5]);
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  localparam logic [P-1:0] PMAX = 18'h1ffff, PMIN = 18'h20000;

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: defaults, extremes, zero distance, far away, small differences.
    send_beat(pack_pos(0, 0, 0, 0, 0, 0));
    send_beat(pack_pos(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
    send_beat(pack_pos(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
    send_beat(pack_pos(PMAX, 0, 0, PMAX, 0, 0));
    send_beat(pack_pos(1, 0, 0, 0, 0, 0));
    send_beat(pack_pos(0, 18'h3ffff, 0, 0, 0, 0));
    send_beat(pack_pos(19661, 0, 0, 0, 0, 0));
    send_beat(pack_pos(19662, 0, 0, 0, 0, 0));
    send_beat(pack_pos(1000, 2000, 3000, 0, 0, 0));
    drain();
    // Strong quadratic term: negative speed and its saturation.
    write_reg(pvc_pkg::REG_GAIN, 0);
    write_reg(pvc_pkg::REG_QUAD, 32'hffffffff);
    write_reg(pvc_pkg::REG_MAX, 65535);
    write_reg(pvc_pkg::REG_FAR, 32'h7ffff);
    send_beat(pack_pos(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
    send_beat(pack_pos(18'h10000, 0, 0, 0, 0, 0));
    send_beat(pack_pos(5000, 6000, 0, 0, 0, 0));
    send_beat(pack_pos(0, 0, 1, 0, 0, 0));
    drain();
    write_reg(pvc_pkg::REG_GAIN, 65535);
    write_reg(pvc_pkg::REG_QUAD, 0);
    write_reg(pvc_pkg::REG_FAR, 0);
    send_beat(pack_pos(1, 1, 1, 0, 0, 0));
    send_beat(pack_pos(PMIN, 5, PMAX, 5, 0, 7));
    drain();
    // Long hold-off so the block fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (100) send_beat(random_pos());
    join
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pvc_pkg::REG_GAIN, (ph == 1) ? 0 : $urandom_range(65535));
      write_reg(pvc_pkg::REG_QUAD, (ph == 2) ? 65535 : $urandom_range(65535));
      write_reg(pvc_pkg::REG_MAX, (ph == 3) ? 0 : $urandom_range(65535));
      write_reg(pvc_pkg::REG_FAR, (ph == 4) ? 32'h7ffff : $urandom_range(200000));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (250) send_beat(random_pos());
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/pvc_pkg.sv
design/pvc_front.sv
design/pvc_fifo.sv
design/pvc_back.sv
design/position_to_velocity_command.sv
tb/pvc_checker.sv
tb/tb_top.sv
